// ----- rtl/core/srmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmt_pkg
// Shared types, sizes and codes of the sorted region map table.
// ----------------------------------------------------------------------------
package srmt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int PAGE_SHIFT    = 12;
	localparam int ADDR_BITS     = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam logic [ADDR_BITS-1:0] PAGE_MASK =
		ADDR_BITS'((64'(1) << PAGE_SHIFT) - 64'(1));

	// action codes
	localparam logic [1:0] ACT_MAP    = 2'd0;
	localparam logic [1:0] ACT_UNMAP  = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_MISALIGNED = 3'd1;
	localparam logic [2:0] ST_OVERLAP    = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
	localparam logic [2:0] ST_PAST_END   = 3'd5;

	typedef struct packed {
		logic [1:0]           action;
		logic [ADDR_BITS-1:0] virt_addr;
		logic [ADDR_BITS-1:0] phys_addr;
		logic [31:0]          region_size;
		logic [7:0]           map_flags;
		logic [3:0]           entry_index;
	} srmt_req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ADDR_BITS-1:0] phys_out;
		logic [ADDR_BITS-1:0] virt_out;
		logic [31:0]          size_out;
		logic [7:0]           flags_out;
	} srmt_rsp_t;

	// one stored mapping
	typedef struct packed {
		logic [ADDR_BITS-1:0] virt;
		logic [ADDR_BITS-1:0] phys;
		logic [31:0]          size;
		logic [7:0]           flags;
	} srmt_entry_t;

	// table port control
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
	} srmt_tbl_ctrl_t;

	// shared compare unit operands: a < b + c, a == b
	typedef struct packed {
		logic [ADDR_BITS-1:0] a;
		logic [ADDR_BITS-1:0] b;
		logic [31:0]          c;
	} srmt_cmp_req_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} srmt_cmp_res_t;

endpackage

// ----- rtl/core/srmt_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmt_table
// Entry storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module srmt_table
	import srmt_pkg::*;
(
	input  logic           clk,
	input  srmt_tbl_ctrl_t ctrl,
	input  srmt_entry_t    wdata,
	output srmt_entry_t    rdata
);

	srmt_entry_t mem [TABLE_ENTRIES];
	srmt_entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rdata_q <= mem[ctrl.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/srmt_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmt_cmp
// Shared compare unit: one wide add with an unsigned compare and an equality.
// ----------------------------------------------------------------------------
module srmt_cmp
	import srmt_pkg::*;
(
	input  srmt_cmp_req_t req,
	output srmt_cmp_res_t res
);

	logic [ADDR_BITS:0] sum;
	logic [ADDR_BITS:0] lhs;

	// end of interval computed one bit wider, so it never wraps
	always_comb begin
		sum    = {1'b0, req.b} + (ADDR_BITS + 1)'(req.c);
		lhs    = {1'b0, req.a};
		res.lt = lhs < sum;
		res.eq = req.a == req.b;
	end

endmodule

// ----- rtl/core/sorted_region_map_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_region_map_table_core
// Sorted table of address mappings with map, unmap, lookup and read actions.
// ----------------------------------------------------------------------------
//   req (req_valid/req_ready) carries one action item; rsp (rsp_valid/
//   rsp_ready) returns exactly one result item for it, in order.
//   req_ready is high only while the sequencer is idle. Entries sit in a
//   memory with registered reads; each entry visited takes a read state and
//   then a compare state in the shared compare unit.
//   The next item can be accepted in the cycle after the result is loaded.
//   Reset empties the table at once (count to zero, no clearing pass).
//   A result waits in the output register while rsp_ready is low; the next
//   item is taken meanwhile, and its result is held until the register frees.
// ----------------------------------------------------------------------------
module sorted_region_map_table_core
	import srmt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  srmt_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output srmt_rsp_t rsp
);

	// sequencer states
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_WALK_RD = 5'd1;
	localparam logic [4:0] S_WALK_EV = 5'd2;
	localparam logic [4:0] S_AFT_RD  = 5'd3;
	localparam logic [4:0] S_AFT_A   = 5'd4;
	localparam logic [4:0] S_AFT_B   = 5'd5;
	localparam logic [4:0] S_BEF_RD  = 5'd6;
	localparam logic [4:0] S_BEF_A   = 5'd7;
	localparam logic [4:0] S_BEF_B   = 5'd8;
	localparam logic [4:0] S_FULL    = 5'd9;
	localparam logic [4:0] S_SH_RD   = 5'd10;
	localparam logic [4:0] S_SH_WR   = 5'd11;
	localparam logic [4:0] S_INS     = 5'd12;
	localparam logic [4:0] S_FIND_RD = 5'd13;
	localparam logic [4:0] S_FIND_EV = 5'd14;
	localparam logic [4:0] S_UN_RD   = 5'd15;
	localparam logic [4:0] S_UN_WR   = 5'd16;
	localparam logic [4:0] S_READ_EV = 5'd17;
	localparam logic [4:0] S_DONE    = 5'd18;

	logic [4:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] slot_q;
	srmt_req_t        req_q;
	srmt_rsp_t        res_q;
	srmt_rsp_t        rsp_q;
	logic             rsp_valid_q;

	srmt_tbl_ctrl_t   tbl_ctrl;
	srmt_entry_t      tbl_wdata;
	srmt_entry_t      tbl_rdata;
	srmt_cmp_req_t    cmp_req;
	srmt_cmp_res_t    cmp_res;

	logic [CNT_W-1:0] ptr_inc;
	logic [CNT_W-1:0] ptr_dec;
	logic [CNT_W-1:0] slot_dec;
	logic             req_misaligned;
	logic             req_past_end;

	assign ptr_inc  = ptr_q + CNT_W'(1);
	assign ptr_dec  = ptr_q - CNT_W'(1);
	assign slot_dec = slot_q - CNT_W'(1);

	assign req_misaligned = |((req.phys_addr | req.virt_addr) & PAGE_MASK);
	assign req_past_end   = 32'(req.entry_index) >= 32'(cnt_q);

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// table port addressing per state
	always_comb begin
		tbl_ctrl  = '0;
		tbl_wdata = tbl_rdata;
		case (state_q)
			S_IDLE: begin
				tbl_ctrl.rd_en   = req_valid && req.action == ACT_READ;
				tbl_ctrl.rd_addr = IDX_W'(req.entry_index);
			end
			S_WALK_RD, S_FIND_RD: begin
				tbl_ctrl.rd_en   = ptr_q != cnt_q;
				tbl_ctrl.rd_addr = ptr_q[IDX_W-1:0];
			end
			S_AFT_RD: begin
				tbl_ctrl.rd_en   = slot_q < cnt_q;
				tbl_ctrl.rd_addr = slot_q[IDX_W-1:0];
			end
			S_BEF_RD: begin
				tbl_ctrl.rd_en   = slot_q != '0;
				tbl_ctrl.rd_addr = slot_dec[IDX_W-1:0];
			end
			S_SH_RD: begin
				tbl_ctrl.rd_en   = ptr_q > slot_q;
				tbl_ctrl.rd_addr = ptr_dec[IDX_W-1:0];
			end
			S_SH_WR, S_UN_WR: begin
				tbl_ctrl.wr_en   = 1'b1;
				tbl_ctrl.wr_addr = ptr_q[IDX_W-1:0];
			end
			S_INS: begin
				tbl_ctrl.wr_en   = 1'b1;
				tbl_ctrl.wr_addr = slot_q[IDX_W-1:0];
				tbl_wdata.virt   = req_q.virt_addr;
				tbl_wdata.phys   = req_q.phys_addr;
				tbl_wdata.size   = req_q.region_size;
				tbl_wdata.flags  = req_q.map_flags;
			end
			S_UN_RD: begin
				tbl_ctrl.rd_en   = ptr_inc < cnt_q;
				tbl_ctrl.rd_addr = ptr_inc[IDX_W-1:0];
			end
			default: begin
				tbl_ctrl = '0;
			end
		endcase
	end

	// compare unit operands per state
	always_comb begin
		cmp_req = '0;
		case (state_q)
			S_WALK_EV: begin
				cmp_req.a = req_q.virt_addr;
				cmp_req.b = tbl_rdata.virt;
			end
			S_FIND_EV: begin
				cmp_req.a = tbl_rdata.virt;
				cmp_req.b = req_q.virt_addr;
			end
			S_AFT_A, S_BEF_A: begin
				cmp_req.a = tbl_rdata.virt;
				cmp_req.b = req_q.virt_addr;
				cmp_req.c = req_q.region_size;
			end
			S_AFT_B, S_BEF_B: begin
				cmp_req.a = req_q.virt_addr;
				cmp_req.b = tbl_rdata.virt;
				cmp_req.c = tbl_rdata.size;
			end
			default: begin
				cmp_req = '0;
			end
		endcase
	end

	srmt_table u_table (
		.clk   (clk),
		.ctrl  (tbl_ctrl),
		.wdata (tbl_wdata),
		.rdata (tbl_rdata)
	);

	srmt_cmp u_cmp (
		.req (cmp_req),
		.res (cmp_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			slot_q      <= '0;
			req_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop a taken result unless a new one is loaded in its place
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						res_q <= '0;
						ptr_q <= '0;
						case (req.action)
							ACT_MAP: begin
								if (req_misaligned) begin
									res_q.status <= ST_MISALIGNED;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_WALK_RD;
								end
							end
							ACT_UNMAP, ACT_LOOKUP: begin
								state_q <= S_FIND_RD;
							end
							default: begin
								if (req_past_end) begin
									res_q.status <= ST_PAST_END;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_READ_EV;
								end
							end
						endcase
					end
				end
				// map: find the slot after all entries not above the new start
				S_WALK_RD: begin
					if (ptr_q == cnt_q) begin
						slot_q  <= ptr_q;
						state_q <= S_AFT_RD;
					end else begin
						state_q <= S_WALK_EV;
					end
				end
				S_WALK_EV: begin
					if (!cmp_res.lt) begin
						ptr_q   <= ptr_inc;
						state_q <= S_WALK_RD;
					end else begin
						slot_q  <= ptr_q;
						state_q <= S_AFT_RD;
					end
				end
				// overlap with the following neighbor
				S_AFT_RD: begin
					state_q <= (slot_q < cnt_q) ? S_AFT_A : S_BEF_RD;
				end
				S_AFT_A: begin
					state_q <= cmp_res.lt ? S_AFT_B : S_BEF_RD;
				end
				S_AFT_B: begin
					if (cmp_res.lt) begin
						res_q.status <= ST_OVERLAP;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_BEF_RD;
					end
				end
				// overlap with the preceding neighbor
				S_BEF_RD: begin
					state_q <= (slot_q != '0) ? S_BEF_A : S_FULL;
				end
				S_BEF_A: begin
					state_q <= cmp_res.lt ? S_BEF_B : S_FULL;
				end
				S_BEF_B: begin
					if (cmp_res.lt) begin
						res_q.status <= ST_OVERLAP;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FULL;
					end
				end
				S_FULL: begin
					if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
						res_q.status <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						ptr_q   <= cnt_q;
						state_q <= S_SH_RD;
					end
				end
				// move entries up one slot, top first
				S_SH_RD: begin
					state_q <= (ptr_q > slot_q) ? S_SH_WR : S_INS;
				end
				S_SH_WR: begin
					ptr_q   <= ptr_dec;
					state_q <= S_SH_RD;
				end
				S_INS: begin
					cnt_q        <= cnt_q + CNT_W'(1);
					res_q.status <= ST_OK;
					state_q      <= S_DONE;
				end
				// unmap and lookup: first entry not below the address
				S_FIND_RD: begin
					if (ptr_q == cnt_q) begin
						res_q.status <= ST_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FIND_EV;
					end
				end
				S_FIND_EV: begin
					if (cmp_res.lt) begin
						ptr_q   <= ptr_inc;
						state_q <= S_FIND_RD;
					end else if (cmp_res.eq) begin
						if (req_q.action == ACT_LOOKUP) begin
							res_q.phys_out <= tbl_rdata.phys;
							state_q        <= S_DONE;
						end else begin
							res_q.size_out <= tbl_rdata.size;
							state_q        <= S_UN_RD;
						end
					end else begin
						res_q.status <= ST_NOT_FOUND;
						state_q      <= S_DONE;
					end
				end
				// move entries down over the removed one
				S_UN_RD: begin
					if (ptr_inc < cnt_q) begin
						state_q <= S_UN_WR;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_UN_WR: begin
					ptr_q   <= ptr_inc;
					state_q <= S_UN_RD;
				end
				S_READ_EV: begin
					res_q.phys_out  <= tbl_rdata.phys;
					res_q.virt_out  <= tbl_rdata.virt;
					res_q.size_out  <= tbl_rdata.size;
					res_q.flags_out <= tbl_rdata.flags;
					state_q         <= S_DONE;
				end
				// hand the result to the output register once it is free
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count above table size");

	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctrl.wr_en |-> (state_q == S_SH_WR || state_q == S_INS || state_q == S_UN_WR))
		else $error("table written outside map or unmap");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the table");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_OK) |->
		(rsp_q.phys_out == '0 && rsp_q.virt_out == '0 &&
		 rsp_q.size_out == '0 && rsp_q.flags_out == '0))
		else $error("error result carries data");

	a_walk_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK_RD || state_q == S_FIND_RD) |-> ptr_q <= cnt_q)
		else $error("walk pointer past end of table");
`endif

endmodule

// ----- verif/sorted_region_map_table_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_region_map_table_core_tb
// Self-checking bench for the sorted region map table: a short list of opening
// requests covers the empty table, alignment errors, neighbor overlap, equal
// starts and reads past the end. Random grow and shrink phases then fill and
// drain the table. Every result is checked field by field against a local
// model or a typed-in status, with random gaps and stalls on both handshakes.
// ----------------------------------------------------------------------------
module sorted_region_map_table_core_tb;
	import srmt_pkg::*;

	localparam int     RANDOM_ITEMS = 1800;
	localparam int     QUIET_TAIL   = 200;
	localparam int     DRAIN_CYCLES = 100;
	localparam longint CYCLE_LIMIT  = 1000000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	srmt_req_t req;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	srmt_rsp_t rsp;

	sorted_region_map_table_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// local copy of the table, kept sorted by virtual start
	logic [ADDR_BITS-1:0] tbl_virt  [TABLE_ENTRIES];
	logic [ADDR_BITS-1:0] tbl_phys  [TABLE_ENTRIES];
	logic [31:0]          tbl_size  [TABLE_ENTRIES];
	logic [7:0]           tbl_flags [TABLE_ENTRIES];
	int                   tbl_count = 0;

	srmt_rsp_t awaited_results [$];
	int        mismatch_count = 0;
	int        action_sent [4] = '{default: 0};
	int        status_seen [8] = '{default: 0};
	longint    cycle_count = 0;
	bit        idle_on = 1'b1;
	int        stall_left = 0;

	// opening requests; st is typed in only where typed is set
	typedef struct {
		logic [1:0]           act;
		logic [ADDR_BITS-1:0] va;
		logic [ADDR_BITS-1:0] pa;
		logic [31:0]          sz;
		logic [7:0]           fl;
		logic [3:0]           ix;
		bit                   typed;
		logic [2:0]           st;
	} plan_row_t;

	localparam int PLAN_ROWS = 24;
	plan_row_t opening_plan [PLAN_ROWS] = '{
		// empty table
		'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b1, ST_PAST_END},
		'{ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b1, ST_NOT_FOUND},
		'{ACT_UNMAP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1, ST_NOT_FOUND},
		// misaligned physical, virtual, both
		'{ACT_MAP,    32'h0000_0000, 32'h0000_0001, 32'h0000_1000, 8'hFF, 4'h0, 1'b1, ST_MISALIGNED},
		'{ACT_MAP,    32'h0000_0FFF, 32'h0000_0000, 32'h0000_1000, 8'h00, 4'h0, 1'b1, ST_MISALIGNED},
		'{ACT_MAP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1, ST_MISALIGNED},
		// first page, top page with an end past the address space
		'{ACT_MAP,    32'h0000_0000, 32'h0000_0000, 32'h0000_1000, 8'hFF, 4'h0, 1'b1, ST_OK},
		'{ACT_MAP,    32'hFFFF_F000, 32'hFFFF_F000, 32'hFFFF_FFFF, 8'h00, 4'h0, 1'b1, ST_OK},
		// zero size touching the first page, then an equal start after it
		'{ACT_MAP,    32'h0000_1000, 32'h8000_0000, 32'h0000_0000, 8'h5A, 4'h0, 1'b1, ST_OK},
		'{ACT_MAP,    32'h0000_1000, 32'h4000_0000, 32'h0000_1000, 8'hA5, 4'h0, 1'b1, ST_OK},
		// overlap with the neighbor before, then the one after
		'{ACT_MAP,    32'h0000_0000, 32'h0000_0000, 32'h0000_1000, 8'h00, 4'h0, 1'b1, ST_OVERLAP},
		'{ACT_MAP,    32'hFFFF_E000, 32'h0000_0000, 32'h0000_2000, 8'h00, 4'h0, 1'b1, ST_OVERLAP},
		// touching the end of the previous mapping
		'{ACT_MAP,    32'h0000_2000, 32'h0000_2000, 32'h0000_1000, 8'h00, 4'h0, 1'b1, ST_OK},
		'{ACT_LOOKUP, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b0, ST_OK},
		'{ACT_LOOKUP, 32'hFFFF_F000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b0, ST_OK},
		'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b0, ST_OK},
		'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h4, 1'b0, ST_OK},
		'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h5, 1'b1, ST_PAST_END},
		'{ACT_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1, ST_PAST_END},
		// removal of the first of two equal starts
		'{ACT_UNMAP,  32'h0000_1000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b0, ST_OK},
		'{ACT_LOOKUP, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b0, ST_OK},
		'{ACT_UNMAP,  32'h0000_1800, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b1, ST_NOT_FOUND},
		'{ACT_UNMAP,  32'hFFFF_F000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b0, ST_OK},
		'{ACT_LOOKUP, 32'hFFFF_F000, 32'h0000_0000, 32'h0000_0000, 8'h00, 4'h0, 1'b1, ST_NOT_FOUND}
	};

	// half-open intervals, ends taken without wrap
	function automatic bit regions_intersect(input logic [ADDR_BITS-1:0] a,
		input logic [31:0] s, input logic [ADDR_BITS-1:0] b, input logic [31:0] t);
		return (65'(a) < 65'(b) + 65'(t)) && (65'(b) < 65'(a) + 65'(s));
	endfunction

	// applies one request to the local table and returns its result
	function automatic srmt_rsp_t predict_table_action(input srmt_req_t r);
		srmt_rsp_t res;
		int        slot;
		int        i;
		res        = '0;
		res.status = ST_OK;
		case (r.action)
			ACT_MAP: begin
				slot = 0;
				while (slot < tbl_count && tbl_virt[slot] <= r.virt_addr) slot++;
				if ((r.phys_addr & PAGE_MASK) != '0 || (r.virt_addr & PAGE_MASK) != '0) begin
					res.status = ST_MISALIGNED;
				end else if (slot > 0 && regions_intersect(tbl_virt[slot-1], tbl_size[slot-1],
						r.virt_addr, r.region_size)) begin
					res.status = ST_OVERLAP;
				end else if (slot < tbl_count && regions_intersect(tbl_virt[slot], tbl_size[slot],
						r.virt_addr, r.region_size)) begin
					res.status = ST_OVERLAP;
				end else if (tbl_count >= TABLE_ENTRIES) begin
					res.status = ST_FULL;
				end else begin
					// open a slot by moving the upper entries up
					for (i = tbl_count; i > slot; i--) begin
						tbl_virt[i]  = tbl_virt[i-1];
						tbl_phys[i]  = tbl_phys[i-1];
						tbl_size[i]  = tbl_size[i-1];
						tbl_flags[i] = tbl_flags[i-1];
					end
					tbl_virt[slot]  = r.virt_addr;
					tbl_phys[slot]  = r.phys_addr;
					tbl_size[slot]  = r.region_size;
					tbl_flags[slot] = r.map_flags;
					tbl_count++;
				end
			end
			ACT_UNMAP, ACT_LOOKUP: begin
				i = 0;
				while (i < tbl_count && tbl_virt[i] < r.virt_addr) i++;
				if (i >= tbl_count || tbl_virt[i] != r.virt_addr) begin
					res.status = ST_NOT_FOUND;
				end else if (r.action == ACT_LOOKUP) begin
					res.phys_out = tbl_phys[i];
				end else begin
					res.size_out = tbl_size[i];
					while (i + 1 < tbl_count) begin
						tbl_virt[i]  = tbl_virt[i+1];
						tbl_phys[i]  = tbl_phys[i+1];
						tbl_size[i]  = tbl_size[i+1];
						tbl_flags[i] = tbl_flags[i+1];
						i++;
					end
					tbl_count--;
				end
			end
			ACT_READ: begin
				if (r.entry_index >= tbl_count) begin
					res.status = ST_PAST_END;
				end else begin
					res.phys_out  = tbl_phys[r.entry_index];
					res.virt_out  = tbl_virt[r.entry_index];
					res.size_out  = tbl_size[r.entry_index];
					res.flags_out = tbl_flags[r.entry_index];
				end
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// offers one item, waits for it to be taken, then records its result
	task automatic send_item(input srmt_req_t r, input bit typed, input logic [2:0] typed_status);
		srmt_rsp_t want;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		want = predict_table_action(r);
		if (typed) begin
			want        = '0;
			want.status = typed_status;
		end
		awaited_results.push_back(want);
		action_sent[r.action]++;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side stalls in short bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			rsp_ready  <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		srmt_rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing pending, status", rsp.status, '0);
			end else begin
				want = awaited_results.pop_front();
				status_seen[want.status]++;
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.phys_out !== want.phys_out)
					report_mismatch("phys_out", rsp.phys_out, want.phys_out);
				if (rsp.virt_out !== want.virt_out)
					report_mismatch("virt_out", rsp.virt_out, want.virt_out);
				if (rsp.size_out !== want.size_out)
					report_mismatch("size_out", rsp.size_out, want.size_out);
				if (rsp.flags_out !== want.flags_out)
					report_mismatch("flags_out", rsp.flags_out, want.flags_out);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		srmt_req_t            r;
		int                   k;
		int                   n;
		int                   pick;
		int                   map_pct;
		int                   find_pct;
		int                   seg_left;
		logic [ADDR_BITS-1:0] window;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening requests
		for (k = 0; k < PLAN_ROWS; k++) begin
			r.action      = opening_plan[k].act;
			r.virt_addr   = opening_plan[k].va;
			r.phys_addr   = opening_plan[k].pa;
			r.region_size = opening_plan[k].sz;
			r.map_flags   = opening_plan[k].fl;
			r.entry_index = opening_plan[k].ix;
			send_item(r, opening_plan[k].typed, opening_plan[k].st);
		end

		// hold off until the table has answered everything
		req_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);

		// first phase grows the table in a dense window
		seg_left = 80;
		map_pct  = 70;
		find_pct = 15;
		window   = ADDR_BITS'(32'h0001_0000);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(40, 120);
				if ($urandom_range(0, 1) != 0) begin
					map_pct  = 60;
					find_pct = 20;
				end else begin
					map_pct  = 10;
					find_pct = 60;
				end
				case ($urandom_range(0, 3))
					0:       window = '0;
					1:       window = {ADDR_BITS{1'b1}} << (PAGE_SHIFT + 6);
					default: window = ADDR_BITS'($urandom) & ~PAGE_MASK;
				endcase
				idle_on = ($urandom_range(0, 3) != 0);
			end
			seg_left--;
			if (n >= RANDOM_ITEMS - QUIET_TAIL)
				idle_on = 1'b0;

			// drain completely now and then
			if (n % 300 == 150) begin
				req_valid <= 1'b0;
				while (awaited_results.size() != 0) @(posedge clk);
			end

			// all fields random, then shaped by the chosen action
			r.action      = 2'($urandom);
			r.virt_addr   = ADDR_BITS'($urandom);
			r.phys_addr   = ADDR_BITS'($urandom);
			r.region_size = $urandom;
			r.map_flags   = 8'($urandom);
			r.entry_index = 4'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				// noise: leave as drawn
			end else if (pick < 5 + map_pct) begin
				r.action    = ACT_MAP;
				r.virt_addr = window + (ADDR_BITS'($urandom_range(0, 63)) << PAGE_SHIFT);
				r.phys_addr = r.phys_addr & ~PAGE_MASK;
				case ($urandom_range(0, 9))
					0:       r.region_size = '0;
					1:       r.region_size = $urandom;
					2:       r.region_size = $urandom_range(1, 3 << PAGE_SHIFT);
					default: r.region_size = $urandom_range(1, 4) << PAGE_SHIFT;
				endcase
				if ($urandom_range(0, 19) == 0)
					r.virt_addr = r.virt_addr | ADDR_BITS'($urandom_range(1, int'(PAGE_MASK)));
				if ($urandom_range(0, 19) == 0)
					r.phys_addr = r.phys_addr | ADDR_BITS'($urandom_range(1, int'(PAGE_MASK)));
			end else if (pick < 5 + map_pct + find_pct) begin
				r.action = ($urandom_range(0, 1) != 0) ? ACT_UNMAP : ACT_LOOKUP;
				if (tbl_count != 0 && $urandom_range(0, 4) != 0)
					r.virt_addr = tbl_virt[$urandom_range(0, tbl_count - 1)];
				else if ($urandom_range(0, 1) != 0)
					r.virt_addr = window + (ADDR_BITS'($urandom_range(0, 63)) << PAGE_SHIFT);
			end else begin
				r.action = ACT_READ;
				if (tbl_count != 0 && $urandom_range(0, 3) != 0)
					r.entry_index = 4'($urandom_range(0, tbl_count - 1));
			end
			send_item(r, 1'b0, ST_OK);
		end

		// wind down
		req_valid <= 1'b0;
		idle_on = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("items: %0d map, %0d unmap, %0d lookup, %0d read",
			action_sent[ACT_MAP], action_sent[ACT_UNMAP],
			action_sent[ACT_LOOKUP], action_sent[ACT_READ]);
		$display("answers: %0d ok, %0d misaligned, %0d overlap, %0d full, %0d not found,",
			status_seen[ST_OK], status_seen[ST_MISALIGNED], status_seen[ST_OVERLAP],
			status_seen[ST_FULL], status_seen[ST_NOT_FOUND]);
		$display("         %0d past end; %0d mismatches",
			status_seen[ST_PAST_END], mismatch_count);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
